// ===== rtl/binary_image_max_overlap_macros.svh =====
// Assertion macros used by the checker of this block.
// Every macro samples on the rising edge of i_clk.
`ifndef BINARY_IMAGE_MAX_OVERLAP_MACROS_SVH
`define BINARY_IMAGE_MAX_OVERLAP_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define BIMO_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define BIMO_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold on the cycle after a reset edge.
`define BIMO_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

// ===== rtl/bimo_pkg.sv =====
`default_nettype none

package bimo_pkg;

    localparam int MAX_N      = 32;
    localparam int ROW_W      = 32;
    localparam int OVL_W      = 11;
    localparam int N_W        = $clog2(MAX_N + 1);
    localparam int IDX_W      = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int RAM_AW     = IDX_W + 1;
    localparam int RAM_DEPTH  = 2 ** RAM_AW;
    localparam int PC_W       = $clog2(ROW_W + 1);
    localparam int ACC_W      = $clog2(MAX_N * ROW_W + 1);
    localparam int SAT_W      = (ACC_W > OVL_W) ? ACC_W : OVL_W;
    localparam int OVL_HIGH   = (MAX_N * ROW_W > (2 ** OVL_W) - 1) ?
                                ((2 ** OVL_W) - 1) : (MAX_N * ROW_W);
    localparam logic [SAT_W-1:0] OVL_MAX = SAT_W'((2 ** OVL_W) - 1);

    typedef struct packed {
        logic [ROW_W-1:0] row_first;
        logic [ROW_W-1:0] row_second;
        logic             last_row;
    } t_in_word;

    typedef struct packed {
        logic [OVL_W-1:0] max_overlap;
        logic             too_many_rows;
    } t_out_word;

    typedef struct packed {
        logic [ROW_W-1:0] first;
        logic [ROW_W-1:0] second;
    } t_row_pair;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        t_row_pair         data;
    } t_row_wr;

    typedef struct packed {
        logic           bank;
        logic [N_W-1:0] n;
        logic           ovf;
    } t_job;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    function automatic logic [PC_W-1:0] popcount(input logic [ROW_W-1:0] v);
        logic [PC_W-1:0] c;
        c = '0;
        for (int k = 0; k < ROW_W; k++) begin
            c = c + PC_W'(v[k]);
        end
        return c;
    endfunction

    // Columns at or above the image size are masked off.
    function automatic logic [ROW_W-1:0] row_keep(input logic [N_W-1:0] n);
        logic [ROW_W-1:0] k;
        if (int'(n) >= ROW_W) begin
            k = '1;
        end else begin
            k = (ROW_W'(1) << n) - ROW_W'(1);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bimo_ram.sv =====
`default_nettype none

module bimo_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]                       o_rdata_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]                       o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

`default_nettype wire

// ===== rtl/bimo_front.sv =====
`default_nettype none

module bimo_front import bimo_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_word i_in_word,
    output t_row_wr       o_wr,
    output logic          o_push,
    output t_job          o_job,
    input  wire t_release i_release
);

    logic [N_W-1:0] r_rows, n_rows;
    logic           r_ovf, n_ovf;
    logic           r_wbank, n_wbank;
    logic [1:0]     r_busy, n_busy;

    logic           accept;
    logic           room;
    logic [N_W-1:0] rows_after;

    // A bank stays busy from its last row until the search over it is done.
    assign o_in_stall = r_busy[r_wbank];
    assign accept     = i_in_valid && !o_in_stall;
    assign room       = r_rows < N_W'(MAX_N);
    assign rows_after = room ? (r_rows + N_W'(1)) : r_rows;

    assign o_wr.we          = accept && room;
    assign o_wr.addr        = {r_wbank, r_rows[IDX_W-1:0]};
    assign o_wr.data.first  = i_in_word.row_first;
    assign o_wr.data.second = i_in_word.row_second;

    assign o_push   = accept && i_in_word.last_row;
    assign o_job.bank = r_wbank;
    assign o_job.n    = rows_after;
    assign o_job.ovf  = r_ovf || !room;

    always_comb begin
        n_rows  = r_rows;
        n_ovf   = r_ovf;
        n_wbank = r_wbank;
        n_busy  = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (accept) begin
            n_rows = rows_after;
            n_ovf  = r_ovf || !room;
            if (i_in_word.last_row) begin
                n_rows          = '0;
                n_ovf           = 1'b0;
                n_busy[r_wbank] = 1'b1;
                n_wbank         = !r_wbank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= '0;
            r_ovf   <= 1'b0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_rows  <= n_rows;
            r_ovf   <= n_ovf;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bimo_job_queue.sv =====
`default_nettype none

module bimo_job_queue import bimo_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    // Two entries cover every job that can be outstanding, one per bank.
    t_job       r_entry [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_valid = r_count != 2'd0;
    assign o_job   = r_entry[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = !r_wptr;
        end
        if (i_pop) begin
            n_rptr = !r_rptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bimo_back.sv =====
`default_nettype none

module bimo_back import bimo_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_valid,
    input  wire t_job              i_job,
    output logic                   o_pop,
    output logic [RAM_AW-1:0]      o_rd_addr_lo,
    output logic [RAM_AW-1:0]      o_rd_addr_hi,
    input  wire t_row_pair         i_rd_lo,
    input  wire t_row_pair         i_rd_hi,
    output t_release               o_release,
    output logic                   o_out_valid,
    output t_out_word              o_out_word,
    input  wire logic              i_out_stall
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_PC   = 6'b000100,
        S_AC   = 6'b001000,
        S_CM   = 6'b010000,
        S_DN   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_job              r_job, n_job;
    logic [ROW_W-1:0]  r_keep, n_keep;
    logic [IDX_W-1:0]  r_dx, n_dx;
    logic [IDX_W-1:0]  r_dy, n_dy;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [PC_W-1:0]   r_pc [4];
    logic [PC_W-1:0]   n_pc [4];
    logic [ACC_W-1:0]  r_q [4];
    logic [ACC_W-1:0]  n_q [4];
    logic [ACC_W-1:0]  r_best, n_best;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    logic [ROW_W-1:0]  a_lo, b_lo, a_hi, b_hi;
    logic [ACC_W-1:0]  m01, m23, m_all;
    logic [SAT_W-1:0]  best_ext;
    logic              can_out;
    logic              more_i, more_dy, more_dx;

    // Row i and row i + dx of the bank under search.
    assign o_rd_addr_lo = {r_job.bank, r_i};
    assign o_rd_addr_hi = {r_job.bank, r_i + r_dx};

    assign a_lo = i_rd_lo.first  & r_keep;
    assign b_lo = i_rd_lo.second & r_keep;
    assign a_hi = i_rd_hi.first  & r_keep;
    assign b_hi = i_rd_hi.second & r_keep;

    assign m01   = (r_q[0] > r_q[1]) ? r_q[0] : r_q[1];
    assign m23   = (r_q[2] > r_q[3]) ? r_q[2] : r_q[3];
    assign m_all = (m01 > m23) ? m01 : m23;

    assign more_i  = ((N_W+1)'(r_i) + (N_W+1)'(r_dx) + (N_W+1)'(1)) < (N_W+1)'(r_job.n);
    assign more_dy = ((N_W+1)'(r_dy) + (N_W+1)'(1)) < (N_W+1)'(r_job.n);
    assign more_dx = ((N_W+1)'(r_dx) + (N_W+1)'(1)) < (N_W+1)'(r_job.n);

    assign best_ext = SAT_W'(r_best);
    assign can_out  = !r_out_valid || !i_out_stall;

    assign o_pop             = (r_state == S_IDLE) && i_job_valid;
    assign o_release.valid   = (r_state == S_DN) && can_out;
    assign o_release.bank    = r_job.bank;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_keep      = r_keep;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_i         = r_i;
        n_pc        = r_pc;
        n_q         = r_q;
        n_best      = r_best;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_keep  = row_keep(i_job.n);
                    n_dx    = '0;
                    n_dy    = '0;
                    n_i     = '0;
                    n_best  = '0;
                    for (int k = 0; k < 4; k++) begin
                        n_q[k] = '0;
                    end
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_PC;
            end
            S_PC: begin
                n_pc[0] = popcount((a_lo >> r_dy) & b_hi);
                n_pc[1] = popcount(a_lo & (b_hi >> r_dy));
                n_pc[2] = popcount((a_hi >> r_dy) & b_lo);
                n_pc[3] = popcount(a_hi & (b_lo >> r_dy));
                n_state = S_AC;
            end
            S_AC: begin
                for (int k = 0; k < 4; k++) begin
                    n_q[k] = r_q[k] + ACC_W'(r_pc[k]);
                end
                if (more_i) begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_RD;
                end else begin
                    n_state = S_CM;
                end
            end
            S_CM: begin
                if (m_all > r_best) begin
                    n_best = m_all;
                end
                for (int k = 0; k < 4; k++) begin
                    n_q[k] = '0;
                end
                n_i = '0;
                if (more_dy) begin
                    n_dy    = r_dy + IDX_W'(1);
                    n_state = S_RD;
                end else if (more_dx) begin
                    n_dy    = '0;
                    n_dx    = r_dx + IDX_W'(1);
                    n_state = S_RD;
                end else begin
                    n_state = S_DN;
                end
            end
            S_DN: begin
                if (can_out) begin
                    n_out_valid              = 1'b1;
                    n_out_word.max_overlap   = (best_ext > OVL_MAX) ?
                                               OVL_W'(OVL_MAX) : OVL_W'(best_ext);
                    n_out_word.too_many_rows = r_job.ovf;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_keep     <= n_keep;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_i        <= n_i;
        r_pc       <= n_pc;
        r_q        <= n_q;
        r_best     <= n_best;
        r_out_word <= n_out_word;
    end

endmodule

`default_nettype wire

// ===== rtl/binary_image_max_overlap.sv =====
`default_nettype none

// Largest overlap of two square binary images under translation. Each input
// word carries one row of both images, one word per cycle while the input is
// not stalled; the word with last_row set closes the image, whose size n is the
// row count saturated at MAX_N (later rows are dropped and flagged). Rows go
// into one of two banks of a two-read-port row memory, so the next image loads
// while the previous one is searched; input stalls only while both banks wait
// for the search. The search runs over every (dx, dy, row) step with four
// popcounts per row pair: each pair passes the read, popcount and accumulate
// states, each shift ends in a compare state, and a done state hands off the
// result. One result word follows each closed image.
module binary_image_max_overlap import bimo_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    t_row_wr           wr;
    logic              push;
    t_job              push_job;
    logic              pop;
    logic              job_valid;
    t_job              job;
    t_release          release_bank;
    logic [RAM_AW-1:0] rd_addr_lo;
    logic [RAM_AW-1:0] rd_addr_hi;
    t_row_pair         rd_lo;
    t_row_pair         rd_hi;

    bimo_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_wr       (wr),
        .o_push     (push),
        .o_job      (push_job),
        .i_release  (release_bank)
    );

    bimo_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (job)
    );

    bimo_ram #(
        .WIDTH ($bits(t_row_pair)),
        .DEPTH (RAM_DEPTH)
    ) u_rows (
        .i_clk     (i_clk),
        .i_we      (wr.we),
        .i_waddr   (wr.addr),
        .i_wdata   (wr.data),
        .i_raddr_a (rd_addr_lo),
        .o_rdata_a (rd_lo),
        .i_raddr_b (rd_addr_hi),
        .o_rdata_b (rd_hi)
    );

    bimo_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_pop        (pop),
        .o_rd_addr_lo (rd_addr_lo),
        .o_rd_addr_hi (rd_addr_hi),
        .i_rd_lo      (rd_lo),
        .i_rd_hi      (rd_hi),
        .o_release    (release_bank),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word),
        .i_out_stall  (i_out_stall)
    );

endmodule

`default_nettype wire

// ===== rtl/bimo_checker.sv =====
`default_nettype none

`include "binary_image_max_overlap_macros.svh"

module bimo_checker import bimo_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_word  i_in_word,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    localparam logic [OVL_W-1:0] OVL_LIMIT = OVL_W'(OVL_HIGH);

    `BIMO_ASSERT_RST(a_reset_quiet, !o_out_valid && !o_in_stall, "ports not idle after reset")

    `BIMO_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "stalled result word changed")

    `BIMO_ASSERT_IMP(a_overlap_range, o_out_valid, o_out_word.max_overlap <= OVL_LIMIT, "overlap count above the pixel count of a full image")

    // Input stalls only once an image has closed and both banks are taken.
    `BIMO_ASSERT_IMP(a_stall_cause, $rose(o_in_stall), $past(i_in_valid && !o_in_stall && i_in_word.last_row), "input stall without a closed image")

endmodule

bind binary_image_max_overlap bimo_checker u_checker (.*);

`default_nettype wire
